### src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; the guard keeps repeated inclusion harmless.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

### src/lnle_pkg.sv
// Types and constants for the leaky NLMS line enhancer.
// No dependencies.
`timescale 1ns / 1ps

package lnle_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 32;
    localparam int LEAK_W   = 16;
    localparam int STEP_W   = 16;
    localparam int DELAY_W  = 10;
    localparam int LEN_W    = 14;  // holds delay lengths up to 4096 and beyond
    localparam int NUM_W    = STEP_W + 30;
    localparam int MU_W     = 32;
    localparam int KPROD_W  = MU_W + 1 + SAMPLE_W;
    localparam int ACC_W    = 64;

    // register indexes on the config port
    localparam logic [1:0] REG_STEP  = 2'd0;
    localparam logic [1:0] REG_LEAK  = 2'd1;
    localparam logic [1:0] REG_DELAY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PASS1,
        ST_ERR,
        ST_DIV,
        ST_SCALE,
        ST_PASS2
    } state_t;

    typedef struct packed {
        logic shift;   // tap line shift, new sample into cell 0
        logic rotate;  // ring rotate toward cell 0, head value fed to the tail
    } cell_ctl_t;

endpackage

### src/leaky_nlms_line_enhancer.sv
// Top level of the leaky NLMS adaptive line enhancer.
// Depends on lnle_pkg, lnle_cell and lnle_div.
`timescale 1ns / 1ps

// Leaky NLMS line enhancer. Each sample accepted on the s_ stream is written
// to a circular delay store; the sample written delay_length transactions
// earlier (delay_length clamped to 1..MAX_DELAY) enters a TAPS-long tap line,
// and the block returns one error sample (input minus prediction, saturated
// Q1.15) per input on the m_ stream. Steps per input, in order: shift the tap
// line, one full turn of the cell ring for the dot product and tap power,
// register the error and start the divider, the bit-serial normalizing divider
// (46 quotient bits plus its done flag), scale the error, a second full turn
// of the ring for the weight update, and the idle state in which the next
// sample is taken. The result is loaded onto m_ in the error step; a result
// still waiting on m_ holds the engine in the error step. One item is in
// flight at a time; s_tready is high whenever the engine is idle, even while
// a result waits. The delay store is not swept after reset: a fill count marks
// the entries never written, which read as zero. Config registers (APB): 0x0
// step_size, 0x4 leakage, 0x8 delay_length; write only while idle.
module leaky_nlms_line_enhancer #(
    parameter int TAPS      = 64,
    parameter int MAX_DELAY = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_in
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] enhanced_out
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW     = lnle_pkg::SAMPLE_W;
    localparam int WW     = lnle_pkg::WEIGHT_W;
    localparam int PTR_W  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int LEN_W  = lnle_pkg::LEN_W;
    localparam int TCNT_W = $clog2(TAPS);
    localparam int POW_W  = 2 * SW + $clog2(TAPS);
    localparam int KW     = lnle_pkg::KPROD_W;
    localparam logic [TCNT_W-1:0] TAP_LAST = TCNT_W'(TAPS - 1);
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_DELAY);

    // ---------------- config registers ----------------
    logic [lnle_pkg::STEP_W-1:0]  step_size_reg;
    logic [lnle_pkg::LEAK_W-1:0]  leakage_reg;
    logic [lnle_pkg::DELAY_W-1:0] delay_length_reg;
    logic                         cfg_wr;
    logic [1:0]                   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg    <= 16'd655;
            leakage_reg      <= 16'd65529;
            delay_length_reg <= 10'd400;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                lnle_pkg::REG_STEP:  step_size_reg    <= pwdata[15:0];
                lnle_pkg::REG_LEAK:  leakage_reg      <= pwdata[15:0];
                lnle_pkg::REG_DELAY: delay_length_reg <= pwdata[9:0];
                default: ;  // unmapped address, ignored
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            lnle_pkg::REG_STEP:  prdata = {16'd0, step_size_reg};
            lnle_pkg::REG_LEAK:  prdata = {16'd0, leakage_reg};
            lnle_pkg::REG_DELAY: prdata = {22'd0, delay_length_reg};
            default:             prdata = '0;
        endcase
    end

    // ---------------- control ----------------
    lnle_pkg::state_t    state_reg, state_next;
    logic [TCNT_W-1:0]   tcnt_reg, tcnt_next;
    lnle_pkg::cell_ctl_t ctl;
    logic                accept, acc_clr, acc_en, err_load, div_start, k_load, upd_en;
    logic                out_free, div_done;

    assign accept   = s_tvalid & s_tready;
    assign out_free = !m_tvalid | m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lnle_pkg::ST_IDLE:  if (accept) state_next = lnle_pkg::ST_SHIFT;
            lnle_pkg::ST_SHIFT: state_next = lnle_pkg::ST_PASS1;
            lnle_pkg::ST_PASS1: if (tcnt_reg == TAP_LAST) state_next = lnle_pkg::ST_ERR;
            lnle_pkg::ST_ERR:   if (out_free) state_next = lnle_pkg::ST_DIV;
            lnle_pkg::ST_DIV:   if (div_done) state_next = lnle_pkg::ST_SCALE;
            lnle_pkg::ST_SCALE: state_next = lnle_pkg::ST_PASS2;
            lnle_pkg::ST_PASS2: if (tcnt_reg == TAP_LAST) state_next = lnle_pkg::ST_IDLE;
            default:            state_next = lnle_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        ctl.shift  = 1'b0;
        ctl.rotate = 1'b0;
        acc_clr    = 1'b0;
        acc_en     = 1'b0;
        err_load   = 1'b0;
        div_start  = 1'b0;
        k_load     = 1'b0;
        upd_en     = 1'b0;
        tcnt_next  = tcnt_reg;
        unique case (state_reg)
            lnle_pkg::ST_IDLE:  s_tready = 1'b1;
            lnle_pkg::ST_SHIFT: begin
                ctl.shift = 1'b1;
                acc_clr   = 1'b1;
                tcnt_next = '0;
            end
            lnle_pkg::ST_PASS1: begin
                ctl.rotate = 1'b1;
                acc_en     = 1'b1;
                tcnt_next  = tcnt_reg + 1'b1;
            end
            lnle_pkg::ST_ERR: begin
                err_load  = out_free;
                div_start = out_free;
            end
            lnle_pkg::ST_DIV: ;
            lnle_pkg::ST_SCALE: begin
                k_load    = 1'b1;
                tcnt_next = '0;
            end
            lnle_pkg::ST_PASS2: begin
                ctl.rotate = 1'b1;
                upd_en     = 1'b1;
                tcnt_next  = tcnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lnle_pkg::ST_IDLE;
            tcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            tcnt_reg  <= tcnt_next;
        end
    end

    // ---------------- delay store ----------------
    // Written entries are always a prefix [0, fill) since the pointer only
    // counts up from zero and wraps to zero; anything past fill reads as zero.
    logic signed [SW-1:0] store_mem [MAX_DELAY];
    logic signed [SW-1:0] rd_reg;
    logic                 rd_ok_reg;
    logic signed [SW-1:0] sample_reg;
    logic [PTR_W-1:0]     ptr_reg;
    logic [LEN_W-1:0]     fill_reg, fill_next;
    logic [LEN_W-1:0]     len_eff, ptr_ext, ptr_inc;
    logic [PTR_W-1:0]     ptr_next;

    always_comb begin
        if (delay_length_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (LEN_W'(delay_length_reg) > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = LEN_W'(delay_length_reg);
        end
        ptr_ext   = LEN_W'(ptr_reg);
        ptr_inc   = ptr_ext + 1'b1;
        ptr_next  = (ptr_inc >= len_eff) ? '0 : PTR_W'(ptr_inc);
        fill_next = (ptr_inc > fill_reg) ? ptr_inc : fill_reg;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg             <= store_mem[ptr_reg];
            store_mem[ptr_reg] <= $signed(s_tdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg  <= '0;
            fill_reg <= '0;
        end else if (accept) begin
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
        end
        if (accept) begin
            sample_reg <= $signed(s_tdata);
            rd_ok_reg  <= ptr_ext < fill_reg;
        end
    end

    // ---------------- cell ring ----------------
    // Rotation moves every cell toward cell 0; cell 0 is the head the shared
    // datapath reads, and its (possibly updated) value re-enters at the tail.
    logic signed [SW-1:0] x_q [TAPS];
    logic signed [WW-1:0] w_q [TAPS];
    logic signed [SW-1:0] x_new;
    logic signed [WW-1:0] w_fb;

    assign x_new = rd_ok_reg ? rd_reg : '0;

    for (genvar i = 0; i < TAPS; i++) begin : g_cell
        lnle_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .x_left  ((i == 0) ? x_new : x_q[(i == 0) ? 0 : i - 1]),
            .x_right ((i == TAPS - 1) ? x_q[0] : x_q[(i == TAPS - 1) ? 0 : i + 1]),
            .w_right ((i == TAPS - 1) ? w_fb : w_q[(i == TAPS - 1) ? 0 : i + 1]),
            .x_out   (x_q[i]),
            .w_out   (w_q[i])
        );
    end

    // ---------------- pass 1: prediction and tap power ----------------
    logic signed [lnle_pkg::ACC_W-1:0] acc_reg;
    logic        [POW_W-1:0]           pow_reg;
    logic signed [WW+SW-1:0]           mac_prod;
    logic        [2*SW-1:0]            sq_prod;

    assign mac_prod = w_q[0] * x_q[0];
    assign sq_prod  = (2*SW)'(x_q[0] * x_q[0]);

    always_ff @(posedge aclk) begin
        if (acc_clr) begin
            acc_reg <= '0;
            pow_reg <= POW_W'(1);
        end else if (acc_en) begin
            acc_reg <= acc_reg + lnle_pkg::ACC_W'(mac_prod);
            pow_reg <= pow_reg + POW_W'(sq_prod);
        end
    end

    // ---------------- error and output register ----------------
    logic signed [lnle_pkg::ACC_W-1:0] pred, diff;
    logic signed [SW-1:0]              err_sat, err_reg;
    logic                              m_tvalid_reg;
    logic [15:0]                       m_tdata_reg;

    always_comb begin
        pred = acc_reg >>> 30;
        diff = lnle_pkg::ACC_W'(sample_reg) - pred;
        if (diff > 64'sd32767) begin
            err_sat = 16'sh7FFF;
        end else if (diff < -64'sd32768) begin
            err_sat = 16'sh8000;
        end else begin
            err_sat = SW'(diff);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (err_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (err_load) begin
            m_tdata_reg <= err_sat;
            err_reg     <= err_sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- normalized step ----------------
    logic [lnle_pkg::MU_W-1:0] mu_norm;
    logic signed [KW-1:0]      k_reg;

    lnle_div #(
        .DEN_W (POW_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({step_size_reg, 30'd0}),
        .den     (pow_reg),
        .done    (div_done),
        .quo     (mu_norm)
    );

    always_ff @(posedge aclk) begin
        if (k_load) begin
            k_reg <= $signed({1'b0, mu_norm}) * err_reg;
        end
    end

    // ---------------- pass 2: leaky weight update ----------------
    logic signed [KW+SW-1:0]           term_prod;
    logic signed [WW+lnle_pkg::LEAK_W:0] leak_prod;
    logic signed [KW+SW:0]             w_sum;

    always_comb begin
        term_prod = k_reg * x_q[0];
        leak_prod = w_q[0] * $signed({1'b0, leakage_reg});
        w_sum     = (KW+SW+1)'(term_prod >>> 16) + (KW+SW+1)'(leak_prod >>> 16);
        if (!upd_en) begin
            w_fb = w_q[0];
        end else if (w_sum > (KW+SW+1)'(32'sh7FFFFFFF)) begin
            w_fb = 32'sh7FFFFFFF;
        end else if (w_sum < (KW+SW+1)'(32'sh80000000)) begin
            w_fb = 32'sh80000000;
        end else begin
            w_fb = WW'(w_sum);
        end
    end

endmodule

### src/lnle_cell.sv
// One tap cell: holds one tap sample and its weight.
// Depends on lnle_pkg.
`timescale 1ns / 1ps

module lnle_cell (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  lnle_pkg::cell_ctl_t                   ctl,
    input  logic signed [lnle_pkg::SAMPLE_W-1:0]  x_left,
    input  logic signed [lnle_pkg::SAMPLE_W-1:0]  x_right,
    input  logic signed [lnle_pkg::WEIGHT_W-1:0]  w_right,
    output logic signed [lnle_pkg::SAMPLE_W-1:0]  x_out,
    output logic signed [lnle_pkg::WEIGHT_W-1:0]  w_out
);

    logic signed [lnle_pkg::SAMPLE_W-1:0] x_reg, x_next;
    logic signed [lnle_pkg::WEIGHT_W-1:0] w_reg, w_next;

    always_comb begin
        x_next = x_reg;
        w_next = w_reg;
        if (ctl.shift) begin
            x_next = x_left;
        end else if (ctl.rotate) begin
            x_next = x_right;
            w_next = w_right;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            w_reg <= '0;
        end else begin
            x_reg <= x_next;
            w_reg <= w_next;
        end
    end

    assign x_out = x_reg;
    assign w_out = w_reg;

endmodule

### src/lnle_div.sv
// Restoring divider, one quotient bit per cycle, result clamped to 32 bits.
// Depends on lnle_pkg.
`timescale 1ns / 1ps

module lnle_div #(
    parameter int DEN_W = 38
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [lnle_pkg::NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]              den,
    output logic                          done,
    output logic [lnle_pkg::MU_W-1:0]     quo
);

    localparam int CNT_W = $clog2(lnle_pkg::NUM_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(lnle_pkg::NUM_W - 1);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [DEN_W-1:0]           rem_reg, rem_next;
    logic [DEN_W-1:0]           den_reg, den_next;
    logic [lnle_pkg::NUM_W-1:0] num_reg, num_next;
    logic [lnle_pkg::NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]             trial;
    logic                       fits;

    always_comb begin
        trial     = {rem_reg, num_reg[lnle_pkg::NUM_W-1]};
        fits      = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = den;
            num_next  = num;
        end else if (busy_reg) begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            q_next   = {q_reg[lnle_pkg::NUM_W-2:0], fits};
            num_next = {num_reg[lnle_pkg::NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        num_reg <= num_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = (|q_reg[lnle_pkg::NUM_W-1:lnle_pkg::MU_W]) ? '1
                                                            : q_reg[lnle_pkg::MU_W-1:0];

endmodule

### src/lnle_checker.sv
// Port-level checks for leaky_nlms_line_enhancer, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lnle_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        pready
);

    // a stalled result transaction keeps its data
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // one sample in flight: input closes right after a transaction
    `ASSERT_CLK(a_one_inflight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)
    // a result needs the full tap pass, never the next cycle
    `ASSERT_CLK(a_no_instant, aclk, aresetn, s_tvalid && s_tready |=> !$rose(m_tvalid))
    // reset empties the output
    `ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_tvalid)
    `ASSERT_ALWAYS(a_pready, aclk, pready)

endmodule

bind leaky_nlms_line_enhancer lnle_checker u_lnle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
